/* rtl/pod_pkg.sv */
package pod_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int NUM_PAIRS   = NUM_ENTRIES / 2;
  localparam int NUM_CELLS   = NUM_ENTRIES - 2;

  typedef logic [23:0] color_t;
  typedef logic [17:0] dist_t;
  typedef logic [3:0]  entry_t;

  // ranking token handed from cell to cell
  typedef struct packed {
    logic        vld;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [7:0]  px0;
    logic [7:0]  px1;
    logic [7:0]  px2;
    dist_t       d1;
    dist_t       d2;
    entry_t      n1;
    entry_t      n2;
  } rank_t;

  // absolute difference of two channel values
  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // squared euclidean distance between a palette color and a pixel
  function automatic dist_t sq_dist(input color_t c, input logic [7:0] p0,
                                    input logic [7:0] p1, input logic [7:0] p2);
    logic [7:0]  e0;
    logic [7:0]  e1;
    logic [7:0]  e2;
    logic [15:0] s0;
    logic [15:0] s1;
    logic [15:0] s2;
    e0 = abs_diff(p0, c[7:0]);
    e1 = abs_diff(p1, c[15:8]);
    e2 = abs_diff(p2, c[23:16]);
    s0 = e0 * e0;
    s1 = e1 * e1;
    s2 = e2 * e2;
    sq_dist = {2'b00, s0} + {2'b00, s1} + {2'b00, s2};
  endfunction

endpackage

/* rtl/pod_head.sv */
module pod_head (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic [1:0]      row,
  input  logic [1:0]      col,
  input  logic [7:0]      px0,
  input  logic [7:0]      px1,
  input  logic [7:0]      px2,
  input  pod_pkg::color_t color0,
  input  pod_pkg::color_t color1,
  output pod_pkg::rank_t  rank_out
);
  import pod_pkg::*;

  dist_t da;
  dist_t db;
  rank_t rank_next;

  // distances to the first two entries
  assign da = sq_dist(color0, px0, px1, px2);
  assign db = sq_dist(color1, px0, px1, px2);

  // order the first pair, entry 1 leads only when strictly closer
  always_comb begin
    rank_next.vld = load;
    rank_next.row = row;
    rank_next.col = col;
    rank_next.px0 = px0;
    rank_next.px1 = px1;
    rank_next.px2 = px2;
    if (db < da) begin
      rank_next.d1 = db;
      rank_next.d2 = da;
      rank_next.n1 = entry_t'(1);
      rank_next.n2 = entry_t'(0);
    end else begin
      rank_next.d1 = da;
      rank_next.d2 = db;
      rank_next.n1 = entry_t'(0);
      rank_next.n2 = entry_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_out <= '0;
    end else begin
      rank_out <= rank_next;
    end
  end

endmodule

/* rtl/pod_cell.sv */
module pod_cell (
  input  logic            clk,
  input  logic            rst,
  input  pod_pkg::color_t color,
  input  pod_pkg::entry_t entry_idx,
  input  pod_pkg::rank_t  rank_in,
  output pod_pkg::rank_t  rank_out
);
  import pod_pkg::*;

  dist_t d;
  rank_t rank_next;

  // distance from the passing pixel to this cell's entry
  assign d = sq_dist(color, rank_in.px0, rank_in.px1, rank_in.px2);

  // insert into the two-best ranking, strict compares keep earlier entries on ties
  always_comb begin
    rank_next = rank_in;
    if (d < rank_in.d1) begin
      rank_next.d2 = rank_in.d1;
      rank_next.n2 = rank_in.n1;
      rank_next.d1 = d;
      rank_next.n1 = entry_idx;
    end else if (d < rank_in.d2) begin
      rank_next.d2 = d;
      rank_next.n2 = entry_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_out <= '0;
    end else begin
      rank_out <= rank_next;
    end
  end

endmodule

/* rtl/pod_decide.sv */
module pod_decide (
  input  logic                                      clk,
  input  logic                                      rst,
  input  pod_pkg::rank_t                            rank_in,
  input  pod_pkg::color_t [pod_pkg::NUM_ENTRIES-1:0] entries,
  output logic                                      done,
  output logic [7:0]                                out_c0,
  output logic [7:0]                                out_c1,
  output logic [7:0]                                out_c2,
  output pod_pkg::entry_t                           chosen_entry
);
  import pod_pkg::*;

  // 4x4 bayer matrix, row major
  localparam logic [3:0] BAYER [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  // (16 - t)^2 weight of the nearest distance
  localparam logic [8:0] W_NEAR [16] = '{
    9'd256, 9'd225, 9'd196, 9'd169, 9'd144, 9'd121, 9'd100, 9'd81,
    9'd64,  9'd49,  9'd36,  9'd25,  9'd16,  9'd9,   9'd4,   9'd1
  };

  // t^2 weight of the second distance
  localparam logic [8:0] W_FAR [16] = '{
    9'd0,   9'd1,   9'd4,   9'd9,   9'd16,  9'd25,  9'd36,  9'd49,
    9'd64,  9'd81,  9'd100, 9'd121, 9'd144, 9'd169, 9'd196, 9'd225
  };

  logic [3:0]  thr;
  logic        a_vld;
  logic [26:0] a_lhs;
  logic [26:0] a_rhs;
  entry_t      a_n1;
  entry_t      a_n2;
  entry_t      pick;
  color_t      pick_color;

  assign thr = BAYER[{rank_in.row, rank_in.col}];

  // weighted distances
  always_ff @(posedge clk) begin
    a_lhs <= W_NEAR[thr] * rank_in.d1;
    a_rhs <= W_FAR[thr] * rank_in.d2;
    a_n1  <= rank_in.n1;
    a_n2  <= rank_in.n2;
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= rank_in.vld;
    end
  end

  // threshold test and color lookup
  assign pick       = (a_lhs < a_rhs) ? a_n1 : a_n2;
  assign pick_color = entries[pick];

  always_ff @(posedge clk) begin
    out_c0       <= pick_color[7:0];
    out_c1       <= pick_color[15:8];
    out_c2       <= pick_color[23:16];
    chosen_entry <= pick;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_vld;
    end
  end

endmodule

/* rtl/palette_ordered_dither.sv */
// Ordered 4x4 dither of one 8-bit three-channel pixel onto a 16-entry palette.
// A pixel is taken on every clock in which start is high (busy is only high
// during reset), and its result appears for one cycle with done high once it
// has passed the pipeline; results cannot be held off, so the receiver must
// take each one when done is high. The pipeline holds, in order: one head stage
// that orders entries 0 and 1, fourteen cells that each fold in one further
// entry, then one stage for the weighted distances and one for the threshold
// test and color lookup. Palette writes go through wr_en/wr_index/wr_data and
// take effect at once; write only when no pixel is in flight.
module palette_ordered_dither (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   row_phase,
  input  logic [1:0]   col_phase,
  input  logic [7:0]   pixel_c0,
  input  logic [7:0]   pixel_c1,
  input  logic [7:0]   pixel_c2,
  input  logic         wr_en,
  input  logic [3:0]   wr_index,
  input  logic [47:0]  wr_data,
  output logic         done,
  output logic [7:0]   out_c0,
  output logic [7:0]   out_c1,
  output logic [7:0]   out_c2,
  output logic [3:0]   chosen_entry
);
  import pod_pkg::*;

  logic [47:0]                 pal_pair [NUM_PAIRS];
  color_t [NUM_ENTRIES-1:0]    entries;
  rank_t                       chain [NUM_CELLS+1];
  logic                        load;

  // palette register writes, indexes past the last pair are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
        pal_pair[k] <= '0;
      end
    end else if (wr_en && (wr_index < 4'(NUM_PAIRS))) begin
      pal_pair[wr_index[2:0]] <= wr_data;
    end
  end

  // split pairs into entries
  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      entries[e] = pal_pair[e / 2][(e % 2) * 24 +: 24];
    end
  end

  assign busy = rst;
  assign load = start && !busy;

  // order entries 0 and 1
  pod_head u_head (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .row      (row_phase),
    .col      (col_phase),
    .px0      (pixel_c0),
    .px1      (pixel_c1),
    .px2      (pixel_c2),
    .color0   (entries[0]),
    .color1   (entries[1]),
    .rank_out (chain[0])
  );

  // one cell per remaining entry
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    pod_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .color     (entries[k + 2]),
      .entry_idx (entry_t'(k + 2)),
      .rank_in   (chain[k]),
      .rank_out  (chain[k + 1])
    );
  end

  // threshold decision and output register
  pod_decide u_decide (
    .clk          (clk),
    .rst          (rst),
    .rank_in      (chain[NUM_CELLS]),
    .entries      (entries),
    .done         (done),
    .out_c0       (out_c0),
    .out_c1       (out_c1),
    .out_c2       (out_c2),
    .chosen_entry (chosen_entry)
  );

  // the end of the chain holds a proper two-best ranking
  a_rank_order: assert property (@(posedge clk) disable iff (rst)
    chain[NUM_CELLS].vld |-> (chain[NUM_CELLS].d1 <= chain[NUM_CELLS].d2) &&
                             (chain[NUM_CELLS].n1 != chain[NUM_CELLS].n2))
    else $error("ranking out of order at end of chain");

  // the emitted color is the palette entry named by chosen_entry
  a_color_match: assert property (@(posedge clk) disable iff (rst)
    done |-> ({out_c2, out_c1, out_c0} == entries[chosen_entry]))
    else $error("output color does not match chosen entry");

  // the head stage takes exactly the transfers accepted in the cycle before
  a_head_load: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (chain[0].vld == $past(load)))
    else $error("head stage valid does not follow accepted transfer");

endmodule
